>>> rtl/ffha_pkg.sv
// ffha_pkg: constants, types and state codes for the first-fit heap allocator
// no dependencies
`timescale 1ns / 1ps

package ffha_pkg;

   localparam int HeapBytes   = 65536;
   localparam int BlockBytes  = 64;
   localparam int HeaderBytes = 16;
   localparam int MaxChunks   = 1024;

   localparam int UsableBytes = (HeapBytes / BlockBytes - 1) * BlockBytes;
   localparam int AddrWidth   = $clog2(HeapBytes) + 1;
   localparam int IdxWidth    = $clog2(MaxChunks);
   localparam int CntWidth    = IdxWidth + 1;
   localparam int BlkShift    = $clog2(BlockBytes);

   typedef logic [AddrWidth-1:0] addr_type;
   typedef logic [IdxWidth-1:0]  idx_type;
   typedef logic [CntWidth-1:0]  cnt_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_NO_FIT    = 3'd1,
      STATUS_EMPTY     = 3'd2,
      STATUS_OUTSIDE   = 3'd3,
      STATUS_NOT_ALLOC = 3'd4
   } status_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [15:0] req_size;
      logic [16:0] free_addr;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] payload_addr;
   } rsp_type;

   typedef struct packed {
      addr_type start;
      addr_type bytes;
   } chunk_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FSCAN,
      ST_FWAIT,
      ST_FREMOVE,
      ST_FRM_WAIT,
      ST_UFIND,
      ST_UFWAIT,
      ST_UINS,
      ST_UINS_WAIT,
      ST_ULOOK,
      ST_ULWAIT,
      ST_UDEL,
      ST_UDEL_WAIT,
      ST_FPUSH,
      ST_FPUSH_WAIT,
      ST_MRG0,
      ST_MRG0_WAIT,
      ST_MRG1,
      ST_MRG1_WAIT,
      ST_MRG_DEL,
      ST_MRG_DEL_WAIT,
      ST_DONE
   } state_type;

endpackage

>>> rtl/ffha_table.sv
// ffha_table: one chunk table, a single-port synchronous memory of start/size pairs
// depends on ffha_pkg
`timescale 1ns / 1ps

module ffha_table
   import ffha_pkg::*;
(
   input  logic      clock,
   input  logic      wr_en,
   input  idx_type   addr,
   input  chunk_type wr_data,
   output chunk_type rd_data
);

   chunk_type mem [MaxChunks];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

>>> rtl/first_fit_heap_allocator.sv
// first_fit_heap_allocator: sequencer over a free table and an address-sorted used table
// depends on ffha_pkg and ffha_table
// request latency grows with the table fill, set by the walks and shifts through the
// single-port chunk memories, which read and then write one entry at a time;
// busy is high from start until rsp_valid, one request at a time.
// reset: free table holds one chunk covering the usable heap (entry zero written
// while init_ff is high after reset), used table empty; the receiver cannot stall.
`timescale 1ns / 1ps

module first_fit_heap_allocator
   import ffha_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   cnt_type   fcnt_ff, fcnt_in, ucnt_ff, ucnt_in;
   cnt_type   i_ff, i_in, k_ff, k_in;
   addr_type  need_ff, need_in, start_ff, start_in, bytes_ff, bytes_in;
   chunk_type hold_ff, hold_in, h0_ff, h0_in;
   logic      init_ff;
   logic [2:0]  stat_ff, stat_in;
   logic [15:0] pay_ff, pay_in;

   logic      f_we, u_we;
   idx_type   f_addr, u_addr;
   chunk_type f_wd, u_wd, f_rd, u_rd;

   ffha_table u_free (.clock(clock), .wr_en(f_we), .addr(f_addr), .wr_data(f_wd),
                      .rd_data(f_rd));
   ffha_table u_used (.clock(clock), .wr_en(u_we), .addr(u_addr), .wr_data(u_wd),
                      .rd_data(u_rd));

   addr_type need_calc, fa;
   assign need_calc = addr_type'(((32'(req_data.req_size) + HeaderBytes + BlockBytes - 1)
                                  >> BlkShift) << BlkShift);
   assign fa = addr_type'(req_ff.free_addr) - addr_type'(HeaderBytes);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fcnt_ff  <= cnt_type'(1);
         ucnt_ff  <= '0;
         init_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         fcnt_ff  <= fcnt_in;
         ucnt_ff  <= ucnt_in;
         init_ff  <= 1'b0;
      end
      req_ff    <= req_in;
      i_ff      <= i_in;
      k_ff      <= k_in;
      need_ff   <= need_in;
      start_ff  <= start_in;
      bytes_ff  <= bytes_in;
      hold_ff   <= hold_in;
      h0_ff     <= h0_in;
      stat_ff   <= stat_in;
      pay_ff    <= pay_in;
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff; fcnt_in = fcnt_ff; ucnt_in = ucnt_ff;
      i_in = i_ff; k_in = k_ff; need_in = need_ff; start_in = start_ff;
      bytes_in = bytes_ff; hold_in = hold_ff; h0_in = h0_ff;
      stat_in = stat_ff; pay_in = pay_ff;
      f_we = 1'b0; f_addr = '0; f_wd = '0;
      u_we = 1'b0; u_addr = '0; u_wd = '0;
      busy = (state_ff != ST_IDLE) || init_ff;
      rsp_valid = 1'b0;
      rsp_data.status = stat_ff;
      rsp_data.payload_addr = pay_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (init_ff) begin
               f_we = 1'b1;
               f_wd.start = '0;
               f_wd.bytes = addr_type'(UsableBytes);
            end else if (start) begin
               req_in  = req_data;
               need_in = need_calc;
               stat_in = STATUS_NO_FIT;
               pay_in  = '0;
               i_in    = '0;
               if (req_data.opcode == OP_ALLOC) begin
                  if (req_data.req_size == '0 || 32'(req_data.req_size) > UsableBytes
                      || fcnt_ff == '0 || ucnt_ff >= cnt_type'(MaxChunks)) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_FSCAN;
                  end
               end else begin
                  priority if (ucnt_ff == '0) begin
                     stat_in = STATUS_EMPTY; state_in = ST_DONE;
                  end else if (32'(req_data.free_addr) > HeapBytes) begin
                     stat_in = STATUS_OUTSIDE; state_in = ST_DONE;
                  end else if (32'(req_data.free_addr) < HeaderBytes) begin
                     stat_in = STATUS_NOT_ALLOC; state_in = ST_DONE;
                  end else begin
                     state_in = ST_ULOOK;
                  end
               end
            end
         end
         // first-fit walk over the free table
         ST_FSCAN: begin
            if (i_ff >= fcnt_ff) begin
               state_in = ST_DONE;
            end else begin
               f_addr = i_ff[IdxWidth-1:0];
               state_in = ST_FWAIT;
            end
         end
         ST_FWAIT: begin
            f_addr = i_ff[IdxWidth-1:0];
            if (f_rd.bytes > need_ff) begin
               start_in = f_rd.start;
               f_we = 1'b1;
               f_wd.start = f_rd.start + need_ff;
               f_wd.bytes = f_rd.bytes - need_ff;
               k_in = '0; state_in = ST_UFIND;
            end else if (f_rd.bytes == need_ff) begin
               start_in = f_rd.start;
               k_in = i_ff; state_in = ST_FREMOVE;
            end else begin
               i_in = i_ff + 1'b1; state_in = ST_FSCAN;
            end
         end
         ST_FREMOVE: begin
            if (k_ff + 1'b1 >= fcnt_ff) begin
               fcnt_in = fcnt_ff - 1'b1;
               k_in = '0; state_in = ST_UFIND;
            end else begin
               f_addr = idx_type'(k_ff + 1'b1);
               state_in = ST_FRM_WAIT;
            end
         end
         ST_FRM_WAIT: begin
            f_we = 1'b1; f_addr = k_ff[IdxWidth-1:0]; f_wd = f_rd;
            k_in = k_ff + 1'b1; state_in = ST_FREMOVE;
         end
         // find insertion point in the used table
         ST_UFIND: begin
            if (k_ff >= ucnt_ff) begin
               i_in = ucnt_ff; state_in = ST_UINS;
            end else begin
               u_addr = k_ff[IdxWidth-1:0]; state_in = ST_UFWAIT;
            end
         end
         ST_UFWAIT: begin
            if (u_rd.start < start_ff) begin
               k_in = k_ff + 1'b1; state_in = ST_UFIND;
            end else begin
               i_in = ucnt_ff; state_in = ST_UINS;
            end
         end
         ST_UINS: begin
            if (i_ff == k_ff) begin
               u_we = 1'b1; u_addr = k_ff[IdxWidth-1:0];
               u_wd.start = start_ff; u_wd.bytes = need_ff;
               ucnt_in = ucnt_ff + 1'b1;
               stat_in = STATUS_OK;
               pay_in = 16'(start_ff + addr_type'(HeaderBytes));
               state_in = ST_DONE;
            end else begin
               u_addr = idx_type'(i_ff - 1'b1); state_in = ST_UINS_WAIT;
            end
         end
         ST_UINS_WAIT: begin
            u_we = 1'b1; u_addr = i_ff[IdxWidth-1:0]; u_wd = u_rd;
            i_in = i_ff - 1'b1; state_in = ST_UINS;
         end
         // free: look up the chunk
         ST_ULOOK: begin
            if (i_ff >= ucnt_ff) begin
               stat_in = STATUS_NOT_ALLOC; state_in = ST_DONE;
            end else begin
               u_addr = i_ff[IdxWidth-1:0]; state_in = ST_ULWAIT;
            end
         end
         ST_ULWAIT: begin
            if (u_rd.start == fa) begin
               if (fcnt_ff >= cnt_type'(MaxChunks)) begin
                  state_in = ST_DONE;
               end else begin
                  start_in = fa; bytes_in = u_rd.bytes;
                  k_in = i_ff; state_in = ST_UDEL;
               end
            end else begin
               i_in = i_ff + 1'b1; state_in = ST_ULOOK;
            end
         end
         ST_UDEL: begin
            if (k_ff + 1'b1 >= ucnt_ff) begin
               ucnt_in = ucnt_ff - 1'b1;
               k_in = fcnt_ff; state_in = ST_FPUSH;
            end else begin
               u_addr = idx_type'(k_ff + 1'b1); state_in = ST_UDEL_WAIT;
            end
         end
         ST_UDEL_WAIT: begin
            u_we = 1'b1; u_addr = k_ff[IdxWidth-1:0]; u_wd = u_rd;
            k_in = k_ff + 1'b1; state_in = ST_UDEL;
         end
         // shift the free table up and push the chunk at the head
         ST_FPUSH: begin
            if (k_ff == '0) begin
               f_we = 1'b1; f_wd.start = start_ff; f_wd.bytes = bytes_ff;
               fcnt_in = fcnt_ff + 1'b1;
               stat_in = STATUS_OK;
               if (fcnt_ff != '0) begin
                  i_in = '0; state_in = ST_MRG0;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               f_addr = idx_type'(k_ff - 1'b1); state_in = ST_FPUSH_WAIT;
            end
         end
         ST_FPUSH_WAIT: begin
            f_we = 1'b1; f_addr = k_ff[IdxWidth-1:0]; f_wd = f_rd;
            k_in = k_ff - 1'b1; state_in = ST_FPUSH;
         end
         // merge entry i with entry i+1 when adjacent
         ST_MRG0: begin
            if (i_ff + 1'b1 >= fcnt_ff) begin
               state_in = (i_ff == '0) ? ST_MRG1 : ST_DONE;
               i_in = cnt_type'(1);
            end else begin
               f_addr = i_ff[IdxWidth-1:0]; state_in = ST_MRG0_WAIT;
            end
         end
         ST_MRG0_WAIT: begin
            h0_in = f_rd;
            f_addr = idx_type'(i_ff + 1'b1); state_in = ST_MRG1_WAIT;
         end
         ST_MRG1: begin
            // second merge attempt on entry one
            f_addr = '0; i_in = cnt_type'(1);
            state_in = (fcnt_ff > cnt_type'(2)) ? ST_MRG0 : ST_DONE;
         end
         ST_MRG1_WAIT: begin
            if (h0_ff.start + h0_ff.bytes == f_rd.start) begin
               f_we = 1'b1; f_addr = i_ff[IdxWidth-1:0];
               f_wd.start = h0_ff.start; f_wd.bytes = h0_ff.bytes + f_rd.bytes;
               k_in = i_ff + 1'b1; state_in = ST_MRG_DEL;
            end else if (i_ff == '0) begin
               i_in = cnt_type'(1); state_in = ST_MRG0;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MRG_DEL: begin
            if (k_ff + 1'b1 >= fcnt_ff) begin
               fcnt_in = fcnt_ff - 1'b1; state_in = ST_DONE;
            end else begin
               f_addr = idx_type'(k_ff + 1'b1); state_in = ST_MRG_DEL_WAIT;
            end
         end
         ST_MRG_DEL_WAIT: begin
            f_we = 1'b1; f_addr = k_ff[IdxWidth-1:0]; f_wd = f_rd;
            k_in = k_ff + 1'b1; state_in = ST_MRG_DEL;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
